// File: hw/rtl/dmtp_pkg.sv
`default_nettype none
package dmtp_pkg;

  localparam int HDR_BYTES = 8;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 13;
  localparam int LEN_W     = 16;

  localparam logic [31:0] TAG_TITLE  = 32'h6d696e6d;  // minm
  localparam logic [31:0] TAG_ARTIST = 32'h61736172;  // asar
  localparam logic [31:0] TAG_ALBUM  = 32'h6173616c;  // asal
  localparam logic [31:0] TAG_LIST   = 32'h6d6c6974;  // mlit

  localparam logic [1:0] SEL_TITLE  = 2'd0;
  localparam logic [1:0] SEL_ARTIST = 2'd1;
  localparam logic [1:0] SEL_ALBUM  = 2'd2;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  total_len;
    logic              last;
    logic              first;
    logic [CHAR_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic               run_end;
    logic               ovf;
    logic [COUNT_W-1:0] count;
    logic [CHAR_W-1:0]  chr;
    logic [1:0]         sel;
    kind_t              kind;
  } res_t;

  // slot 0 value byte, slot 1 field complete, slot 2 parse done
  typedef struct packed {
    logic [2:0]      vld;
    res_t [2:0]      slot;
  } res_grp_t;

endpackage
`default_nettype wire

// File: hw/rtl/dmtp_parser.sv
`default_nettype none
module dmtp_parser
  import dmtp_pkg::*;
#(
  parameter int MAX_DEPTH = 4,
  parameter int STR_MAX   = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire item_t    item,
  output res_grp_t      grp
);

  localparam int NLVL  = MAX_DEPTH + 1;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W = $clog2(STR_MAX);

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_VALUE,
    MODE_SKIP,
    MODE_DISCARD
  } mode_t;

  logic [LEN_W-1:0]   region_r   [NLVL];
  logic [LEN_W-1:0]   region_nxt [NLVL];
  logic [LVL_W-1:0]   nest_r, nest_nxt;
  logic [55:0]        hdr_r, hdr_nxt;
  logic [2:0]         seen_r, seen_nxt;
  mode_t              mode_r, mode_nxt;
  logic [LEN_W-1:0]   vleft_r, vleft_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [1:0]         field_r, field_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               ovf_r, ovf_nxt;

  logic [LEN_W-1:0]   cur_left;
  logic [LEN_W-1:0]   left_dec;
  logic [63:0]        hdr_full;
  logic [31:0]        vlen;
  logic [31:0]        code;
  logic [LVL_W-1:0]   lvl_base;
  logic [LVL_W-1:0]   pop_lvl;
  logic               emit_byte;
  logic               emit_cmpl;
  logic               emit_done;

  always_comb begin
    region_nxt = region_r;
    nest_nxt   = nest_r;
    hdr_nxt    = hdr_r;
    seen_nxt   = seen_r;
    mode_nxt   = mode_r;
    vleft_nxt  = vleft_r;
    cap_nxt    = cap_r;
    field_nxt  = field_r;
    total_nxt  = total_r;
    ovf_nxt    = ovf_r;
    emit_byte  = 1'b0;
    emit_cmpl  = 1'b0;
    emit_done  = 1'b0;
    pop_lvl    = '0;

    if (item.first) begin
      for (int j = 0; j < NLVL; j++) begin
        region_nxt[j] = '0;
      end
      region_nxt[0] = item.total_len;
      nest_nxt      = '0;
      hdr_nxt       = '0;
      seen_nxt      = '0;
      mode_nxt      = MODE_HEADER;
      vleft_nxt     = '0;
      cap_nxt       = '0;
      field_nxt     = SEL_TITLE;
      total_nxt     = '0;
      ovf_nxt       = 1'b0;
    end

    lvl_base = nest_nxt;
    cur_left = '0;
    for (int j = 0; j < NLVL; j++) begin
      if (LVL_W'(j) == lvl_base) cur_left = region_nxt[j];
    end
    left_dec = cur_left - LEN_W'(1);
    hdr_full = {hdr_nxt, item.data};
    code     = hdr_full[63:32];
    vlen     = hdr_full[31:0];

    if (cur_left != '0) begin
      // fewer bytes left than a whole header
      if (mode_nxt == MODE_HEADER && seen_nxt == 3'd0 && cur_left < LEN_W'(HDR_BYTES)) begin
        mode_nxt = MODE_DISCARD;
      end
      for (int j = 0; j < NLVL; j++) begin
        if (LVL_W'(j) == lvl_base) region_nxt[j] = left_dec;
      end

      case (mode_nxt)
        MODE_HEADER: begin
          if (seen_nxt == 3'(HDR_BYTES - 1)) begin
            hdr_nxt  = '0;
            seen_nxt = '0;
            if (vlen > {16'd0, left_dec}) begin
              mode_nxt = MODE_DISCARD;
            end else if (code == TAG_LIST) begin
              if (lvl_base == LVL_W'(MAX_DEPTH)) begin
                ovf_nxt   = 1'b1;
                mode_nxt  = MODE_SKIP;
                vleft_nxt = vlen[LEN_W-1:0];
              end else begin
                for (int j = 0; j < NLVL; j++) begin
                  if (LVL_W'(j) == lvl_base) begin
                    region_nxt[j] = left_dec - vlen[LEN_W-1:0];
                  end else if (int'(lvl_base) + 1 == j) begin
                    region_nxt[j] = vlen[LEN_W-1:0];
                  end
                end
                nest_nxt = lvl_base + LVL_W'(1);
              end
            end else if (code == TAG_TITLE || code == TAG_ARTIST || code == TAG_ALBUM) begin
              field_nxt = (code == TAG_TITLE)  ? SEL_TITLE :
                          (code == TAG_ARTIST) ? SEL_ARTIST : SEL_ALBUM;
              if (total_nxt != '1) total_nxt = total_nxt + COUNT_W'(1);
              cap_nxt   = '0;
              vleft_nxt = vlen[LEN_W-1:0];
              mode_nxt  = MODE_VALUE;
              if (vlen == '0) begin
                emit_cmpl = 1'b1;
                mode_nxt  = MODE_HEADER;
              end
            end else begin
              mode_nxt  = MODE_SKIP;
              vleft_nxt = vlen[LEN_W-1:0];
            end
          end else begin
            hdr_nxt  = hdr_full[55:0];
            seen_nxt = seen_nxt + 3'd1;
          end
        end
        MODE_VALUE: begin
          if (cap_nxt < CAP_W'(STR_MAX - 1)) begin
            emit_byte = 1'b1;
            cap_nxt   = cap_nxt + CAP_W'(1);
          end
          if (vleft_nxt != '0) vleft_nxt = vleft_nxt - LEN_W'(1);
          if (vleft_nxt == '0) begin
            emit_cmpl = 1'b1;
            mode_nxt  = MODE_HEADER;
          end
        end
        MODE_SKIP: begin
          if (vleft_nxt != '0) vleft_nxt = vleft_nxt - LEN_W'(1);
          if (vleft_nxt == '0) mode_nxt = MODE_HEADER;
        end
        default: ;
      endcase

      if (mode_nxt == MODE_DISCARD && left_dec == '0) mode_nxt = MODE_HEADER;

      // close every region that ran out, innermost first
      if (mode_nxt == MODE_HEADER) begin
        for (int j = 0; j < NLVL; j++) begin
          if (LVL_W'(j) <= nest_nxt && (j == 0 || region_nxt[j] != '0)) pop_lvl = LVL_W'(j);
        end
        if (pop_lvl != nest_nxt) begin
          hdr_nxt  = '0;
          seen_nxt = '0;
        end
        nest_nxt = pop_lvl;
      end
    end

    if (item.last) begin
      if (mode_nxt == MODE_VALUE) emit_cmpl = 1'b1;
      emit_done = 1'b1;
      for (int j = 0; j < NLVL; j++) begin
        region_nxt[j] = '0;
      end
      nest_nxt  = '0;
      hdr_nxt   = '0;
      seen_nxt  = '0;
      mode_nxt  = MODE_HEADER;
      vleft_nxt = '0;
    end
  end

  always_comb begin
    grp.vld = {emit_done, emit_cmpl, emit_byte};

    grp.slot[0].kind    = KIND_BYTE;
    grp.slot[0].sel     = field_nxt;
    grp.slot[0].chr     = item.data;
    grp.slot[0].count   = total_nxt;
    grp.slot[0].ovf     = ovf_nxt;
    grp.slot[0].run_end = !emit_cmpl && !emit_done;

    grp.slot[1].kind    = KIND_FIELD;
    grp.slot[1].sel     = field_nxt;
    grp.slot[1].chr     = '0;
    grp.slot[1].count   = total_nxt;
    grp.slot[1].ovf     = ovf_nxt;
    grp.slot[1].run_end = !emit_done;

    grp.slot[2].kind    = KIND_DONE;
    grp.slot[2].sel     = SEL_TITLE;
    grp.slot[2].chr     = '0;
    grp.slot[2].count   = total_nxt;
    grp.slot[2].ovf     = ovf_nxt;
    grp.slot[2].run_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NLVL; j++) begin
        region_r[j] <= '0;
      end
      nest_r  <= '0;
      hdr_r   <= '0;
      seen_r  <= '0;
      mode_r  <= MODE_HEADER;
      vleft_r <= '0;
      cap_r   <= '0;
      field_r <= SEL_TITLE;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      region_r <= region_nxt;
      nest_r   <= nest_nxt;
      hdr_r    <= hdr_nxt;
      seen_r   <= seen_nxt;
      mode_r   <= mode_nxt;
      vleft_r  <= vleft_nxt;
      cap_r    <= cap_nxt;
      field_r  <= field_nxt;
      total_r  <= total_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dmtp_out_stage.sv
`default_nettype none
module dmtp_out_stage
  import dmtp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire res_grp_t  grp,
  output logic           grp_free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output res_t           out_res
);

  logic [2:0] grp_vld_r, grp_vld_nxt;
  res_t [2:0] grp_slot_r;
  logic       out_vld_r;
  res_t       out_r;
  logic       take;
  logic [1:0] pick;
  logic [2:0] left_vld;

  always_comb begin
    pick = 2'd0;
    for (int i = 2; i >= 0; i--) begin
      if (grp_vld_r[i]) pick = 2'(i);
    end
  end

  assign take     = (!out_vld_r || out_ready) && (grp_vld_r != 3'd0);
  assign left_vld = take ? (grp_vld_r & ~(3'd1 << pick)) : grp_vld_r;
  // group may be refilled once the transfer in flight empties it
  assign grp_free = (left_vld == 3'd0);

  always_comb begin
    grp_vld_nxt = left_vld;
    if (load) grp_vld_nxt = grp.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      grp_vld_r <= grp_vld_nxt;
      if (take) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp_slot_r <= grp.slot;
    if (take) out_r <= grp_slot_r[pick];
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/dmap_tag_metadata_parser.sv
// path: input register holds the byte, group register its results, output register one result
// throughput: one byte per cycle if out_tready stays high and each byte has at most one result;
//   a byte with two or three results holds the input until the output has taken all of them
// the parse state steps once per byte; the group drains one per cycle while out_tready is high
// reset: synchronous active low, clears all parse state and the in, group and out valid flags
`default_nettype none
module dmap_tag_metadata_parser
  import dmtp_pkg::*;
#(
  parameter int MAX_DEPTH = 4,
  parameter int STR_MAX   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_byte [7:0], total_len [23:8]
  input  wire logic [0:0]  in_tuser,   // first_byte [0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // char_byte [7:0], tag_count [20:8], depth_overflow [21]
  output logic [3:0]       out_tuser,  // kind [1:0], field_sel [3:2]
  output logic             out_tlast
);

  logic     in_vld_r;
  item_t    item_r;
  logic     fire;
  logic     grp_free;
  res_grp_t grp;
  res_t     out_res;

  assign fire      = in_vld_r && grp_free;
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data      <= in_tdata[7:0];
      item_r.total_len <= in_tdata[23:8];
      item_r.first     <= in_tuser[0];
      item_r.last      <= in_tlast;
    end
  end

  dmtp_parser #(
    .MAX_DEPTH (MAX_DEPTH),
    .STR_MAX   (STR_MAX)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .grp   (grp)
  );

  dmtp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .grp       (grp),
    .grp_free  (grp_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.ovf, out_res.count, out_res.chr};
  assign out_tuser = {out_res.sel, out_res.kind};
  assign out_tlast = out_res.run_end;

endmodule
`default_nettype wire

// File: hw/rtl/dmtp_checker.sv
`default_nettype none
module dmtp_checker
  import dmtp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // parse done is always the final result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_DONE |-> out_tlast)
    else $error("parse done without run end");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_DONE |-> out_tuser[3:2] == SEL_TITLE &&
    out_tdata[7:0] == 8'd0)
    else $error("parse done carries field or byte");

  // a field complete closes a field and has no byte
  a_field_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_FIELD |-> out_tdata[7:0] == 8'd0 &&
    out_tuser[3:2] != 2'd3)
    else $error("field complete carries a byte");

endmodule

bind dmap_tag_metadata_parser dmtp_checker u_dmtp_checker (.*);
`default_nettype wire

// File: bench/dmap_tag_metadata_parser_test.sv
`timescale 1ns / 1ps
module dmap_tag_metadata_parser_test;
  import dmtp_pkg::*;

  localparam int MAX_DEPTH  = 4;
  localparam int STR_MAX    = 64;
  localparam int RAND_BYTES = 380;
  localparam int HOLD_START = 150;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 3000;

  typedef enum logic [1:0] {
    SCAN_HDR,
    SCAN_VAL,
    SCAN_SKIP,
    SCAN_DROP
  } scan_mode_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  dmap_tag_metadata_parser #(
    .MAX_DEPTH(MAX_DEPTH),
    .STR_MAX  (STR_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser mirror
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]         rgn_left [0:MAX_DEPTH];
  logic [2:0]               lvl;
  logic [63:0]              hdr_sr;
  logic [3:0]               hdr_cnt;
  scan_mode_t               scan_mode;
  logic [31:0]              val_left;
  logic [$clog2(STR_MAX):0] cap_cnt;
  logic [1:0]               fsel;
  logic [COUNT_W-1:0]       nfields;
  logic                     ovf_flag;

  res_t step_res[$];
  res_t pending_results[$];

  function void restart(logic [LEN_W-1:0] len);
    foreach (rgn_left[i]) rgn_left[i] = '0;
    rgn_left[0] = len;
    lvl       = '0;
    hdr_sr    = '0;
    hdr_cnt   = '0;
    scan_mode = SCAN_HDR;
    val_left  = '0;
    cap_cnt   = '0;
    fsel      = SEL_TITLE;
    nfields   = '0;
    ovf_flag  = 1'b0;
  endfunction

  function void note(kind_t k, logic [1:0] s, logic [7:0] c);
    res_t r;
    r.kind    = k;
    r.sel     = s;
    r.chr     = c;
    r.count   = nfields;
    r.ovf     = ovf_flag;
    r.run_end = 1'b0;
    step_res.push_back(r);
  endfunction

  function void close_header();
    logic [31:0] code;
    logic [31:0] vlen;
    code    = hdr_sr[63:32];
    vlen    = hdr_sr[31:0];
    hdr_cnt = '0;
    hdr_sr  = '0;
    if (vlen > rgn_left[lvl]) begin
      // length overrun: drop what is left of this region
      scan_mode = SCAN_DROP;
    end else if (code == TAG_LIST) begin
      if (lvl >= MAX_DEPTH) begin
        ovf_flag  = 1'b1;
        scan_mode = SCAN_SKIP;
        val_left  = vlen;
      end else begin
        rgn_left[lvl] = rgn_left[lvl] - vlen[LEN_W-1:0];
        lvl           = lvl + 3'd1;
        rgn_left[lvl] = vlen[LEN_W-1:0];
        scan_mode     = SCAN_HDR;
      end
    end else if (code == TAG_TITLE || code == TAG_ARTIST || code == TAG_ALBUM) begin
      fsel = (code == TAG_TITLE) ? SEL_TITLE : (code == TAG_ARTIST) ? SEL_ARTIST : SEL_ALBUM;
      if (nfields != '1) nfields = nfields + COUNT_W'(1);
      cap_cnt   = '0;
      val_left  = vlen;
      scan_mode = SCAN_VAL;
      if (vlen == 0) begin
        note(KIND_FIELD, fsel, 8'd0);
        scan_mode = SCAN_HDR;
      end
    end else begin
      scan_mode = SCAN_SKIP;
      val_left  = vlen;
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    if (rgn_left[lvl] == 0) return;
    // fewer bytes than a header left at a header start
    if (scan_mode == SCAN_HDR && hdr_cnt == 0 && rgn_left[lvl] < HDR_BYTES)
      scan_mode = SCAN_DROP;
    rgn_left[lvl] = rgn_left[lvl] - LEN_W'(1);
    case (scan_mode)
      SCAN_HDR: begin
        hdr_sr  = {hdr_sr[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= HDR_BYTES) close_header();
      end
      SCAN_VAL: begin
        if (cap_cnt < STR_MAX - 1) begin
          note(KIND_BYTE, fsel, b);
          cap_cnt = cap_cnt + 1'b1;
        end
        if (val_left > 0) val_left = val_left - 32'd1;
        if (val_left == 0) begin
          note(KIND_FIELD, fsel, 8'd0);
          scan_mode = SCAN_HDR;
        end
      end
      SCAN_SKIP: begin
        if (val_left > 0) val_left = val_left - 32'd1;
        if (val_left == 0) scan_mode = SCAN_HDR;
      end
      default: ;
    endcase
    if (scan_mode == SCAN_DROP && rgn_left[lvl] == 0) scan_mode = SCAN_HDR;
    // pop every container that has just run out
    while (scan_mode == SCAN_HDR && lvl > 0 && rgn_left[lvl] == 0) begin
      hdr_cnt = '0;
      hdr_sr  = '0;
      lvl     = lvl - 3'd1;
    end
  endfunction

  function void predict_results(item_t it);
    step_res.delete();
    if (it.first) restart(it.total_len);
    parse_byte(it.data);
    if (it.last) begin
      if (scan_mode == SCAN_VAL) note(KIND_FIELD, fsel, 8'd0);
      note(KIND_DONE, 2'd0, 8'd0);
      foreach (rgn_left[i]) rgn_left[i] = '0;
      lvl       = '0;
      hdr_sr    = '0;
      hdr_cnt   = '0;
      scan_mode = SCAN_HDR;
      val_left  = '0;
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].run_end = 1'b1;
    foreach (step_res[i]) pending_results.push_back(step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // buffer builder
  // ---------------------------------------------------------------------------
  logic [7:0] msg_bytes[$];
  item_t      byte_queue[$];

  function void put_hdr(logic [31:0] tag, logic [31:0] len);
    logic [63:0] h;
    h = {tag, len};
    for (int i = 7; i >= 0; i--) msg_bytes.push_back(h[i*8 +: 8]);
  endfunction

  function void put_random(int n);
    repeat (n) msg_bytes.push_back(8'($urandom()));
  endfunction

  function void add_field();
    int r;
    int len;
    logic [31:0] tag;
    r   = $urandom_range(0, 2);
    tag = (r == 0) ? TAG_TITLE : (r == 1) ? TAG_ARTIST : TAG_ALBUM;
    r   = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(0, 6);
    else if (r < 95) len = $urandom_range(7, 20);
    else len = $urandom_range(STR_MAX - 4, STR_MAX + 6);
    put_hdr(tag, len);
    put_random(len);
  endfunction

  function void patch_len(int at);
    logic [31:0] len;
    len = msg_bytes.size() - at - HDR_BYTES;
    for (int i = 0; i < 4; i++) msg_bytes[at + 4 + i] = len[(3-i)*8 +: 8];
  endfunction

  function automatic void add_items(int depth, int cnt);
    int r;
    int n;
    int at;
    repeat (cnt) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_field();
      end else if (r < 75 && depth < 6) begin
        at = msg_bytes.size();
        put_hdr(TAG_LIST, 0);
        add_items(depth + 1, (depth < 2) ? $urandom_range(1, 3) : $urandom_range(0, 1));
        patch_len(at);
      end else begin
        n = $urandom_range(0, 6);
        put_hdr($urandom(), n);
        put_random(n);
      end
    end
  endfunction

  // nested listing items, a field at the innermost level and at random at each level above
  function automatic void add_chain(int levels);
    int at;
    if (levels == 0) begin
      add_field();
    end else begin
      at = msg_bytes.size();
      put_hdr(TAG_LIST, 0);
      if ($urandom_range(0, 1)) add_field();
      add_chain(levels - 1);
      patch_len(at);
    end
  endfunction

  function int push_buffer(logic [LEN_W-1:0] len, bit with_last);
    item_t it;
    foreach (msg_bytes[i]) begin
      it.data      = msg_bytes[i];
      it.first     = (i == 0);
      it.last      = with_last && (i == msg_bytes.size() - 1);
      it.total_len = (i == 0) ? len : LEN_W'($urandom());
      byte_queue.push_back(it);
    end
    return msg_bytes.size();
  endfunction

  function void push_loose(logic [7:0] d, bit first, bit last, logic [LEN_W-1:0] len);
    item_t it;
    it.data      = d;
    it.first     = first;
    it.last      = last;
    it.total_len = len;
    byte_queue.push_back(it);
  endfunction

  function int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  item_t nxt;
  int    drv_gap  = 0;
  int    drv_sent = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (drv_gap > 0) begin
        drv_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        nxt = byte_queue.pop_front();
        in_tdata  <= {nxt.total_len, nxt.data};
        in_tuser  <= nxt.first;
        in_tlast  <= nxt.last;
        in_tvalid <= 1'b1;
        drv_sent++;
        drv_gap = pick_gap(drv_sent[6]);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: random stalls plus one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  int snk_cyc  = 0;
  int snk_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      snk_cyc++;
      if (snk_cyc >= HOLD_START && snk_cyc < HOLD_START + HOLD_LEN) begin
        out_tready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) snk_wait = pick_gap(snk_cyc[7]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input monitor feeds the mirror
  // ---------------------------------------------------------------------------
  item_t in_it;
  int    n_bytes   = 0;
  int    n_buffers = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      restart('0);
    end else if (in_tvalid && in_tready) begin
      in_it.data      = in_tdata[7:0];
      in_it.total_len = in_tdata[23:8];
      in_it.first     = in_tuser[0];
      in_it.last      = in_tlast;
      n_bytes++;
      if (in_it.first) n_buffers++;
      predict_results(in_it);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  res_t got;
  res_t want;
  int   n_err    = 0;
  int   n_res    = 0;
  int   n_fields = 0;
  int   n_done   = 0;
  int   n_ovf    = 0;

  function void cmp_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.chr     = out_tdata[7:0];
      got.count   = out_tdata[20:8];
      got.ovf     = out_tdata[21];
      got.kind    = kind_t'(out_tuser[1:0]);
      got.sel     = out_tuser[3:2];
      got.run_end = out_tlast;
      n_res++;
      if (got.kind == KIND_FIELD) n_fields++;
      if (got.kind == KIND_DONE) begin
        n_done++;
        if (got.ovf) n_ovf++;
      end
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d sel %0d chr 0x%0h",
                 $time, got.kind, got.sel, got.chr);
        n_err++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("kind", want.kind, got.kind);
        cmp_field("field_sel", want.sel, got.sel);
        cmp_field("char_byte", want.chr, got.chr);
        cmp_field("tag_count", want.count, got.count);
        cmp_field("depth_overflow", want.ovf, got.ovf);
        cmp_field("run_end", want.run_end, got.run_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int idle_cyc = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cyc, pending_results.size());
        $display("FAIL dmap_tag_metadata_parser");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int rand_cnt;
    int r;
    int sz;
    int keep;
    logic [LEN_W-1:0] len;

    // bytes outside any buffer, empty buffer, short title and empty album
    push_loose(8'hFF, 1'b0, 1'b0, 16'hFFFF);
    push_loose(8'h00, 1'b0, 1'b1, 16'h0000);
    push_loose(8'hAA, 1'b1, 1'b1, 16'h0000);
    msg_bytes.delete();
    put_hdr(TAG_TITLE, 1);
    msg_bytes.push_back(8'hFF);
    put_hdr(TAG_ALBUM, 0);
    void'(push_buffer(LEN_W'(msg_bytes.size()), 1'b1));
    // partial header, then a full-length buffer that ends on its first byte
    msg_bytes = '{8'h6d, 8'h69, 8'h00};
    void'(push_buffer(LEN_W'(3), 1'b1));
    push_loose(8'h00, 1'b1, 1'b1, 16'hFFFF);

    rand_cnt = 0;
    while (rand_cnt < RAND_BYTES) begin
      msg_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_items(0, $urandom_range(1, 4));
        rand_cnt += push_buffer(LEN_W'(msg_bytes.size()), 1'b1);
      end else if (r < 58) begin
        add_chain($urandom_range(MAX_DEPTH, MAX_DEPTH + 2));
        add_items(0, $urandom_range(0, 2));
        rand_cnt += push_buffer(LEN_W'(msg_bytes.size()), 1'b1);
      end else if (r < 68) begin
        // last flag may arrive before the buffer is used up
        add_items(0, $urandom_range(1, 4));
        sz   = msg_bytes.size();
        keep = $urandom_range(1, sz);
        msg_bytes = msg_bytes[0:keep-1];
        rand_cnt += push_buffer(LEN_W'(sz), 1'b1);
      end else if (r < 76) begin
        // bytes past total_len
        add_items(0, $urandom_range(1, 3));
        len = LEN_W'(msg_bytes.size());
        put_random($urandom_range(1, 3));
        rand_cnt += push_buffer(len, 1'b1);
      end else if (r < 86) begin
        add_items(0, $urandom_range(1, 4));
        sz = msg_bytes.size();
        if ($urandom_range(0, 1)) begin
          len = LEN_W'($urandom_range(0, sz));
        end else begin
          len = LEN_W'(sz);
          msg_bytes[$urandom_range(0, sz - 1)] = 8'($urandom());
        end
        rand_cnt += push_buffer(len, 1'b1);
      end else if (r < 95) begin
        put_random($urandom_range(1, 12));
        rand_cnt += push_buffer(LEN_W'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 3)) push_loose(8'($urandom()), 1'b0, 1'b0, 16'($urandom()));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() > 0 || in_tvalid || pending_results.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d buffers in %0d byte transfers, %0d result transfers",
             n_buffers, n_bytes, n_res);
    $display("  %0d field ends, %0d done reports, %0d of them with depth overflow",
             n_fields, n_done, n_ovf);
    if (n_err == 0) begin
      $display("PASS dmap_tag_metadata_parser");
    end else begin
      $display("FAIL dmap_tag_metadata_parser");
    end
    $finish;
  end

endmodule
